### rtl/slfd_pkg.sv
// ----------------------------------------------------------------------------
// slfd_pkg: shared types for the sync/length frame deframer
// Phase codes, event kinds, the result record and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package slfd_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hA5;
	localparam logic [7:0] SYNC_SECOND = 8'h5A;
	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam logic [7:0] CRC_TOP     = 8'h80;
	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd64;

	typedef enum logic [8:0] {
		PH_HUNT    = 9'b000000001,
		PH_SYNC2   = 9'b000000010,
		PH_OPCODE  = 9'b000000100,
		PH_LENHI   = 9'b000001000,
		PH_LENLO   = 9'b000010000,
		PH_PAYLOAD = 9'b000100000,
		PH_CRC     = 9'b001000000,
		PH_TRAILER = 9'b010000000,
		PH_SKIP    = 9'b100000000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_BAD      = 2'd2,
		KIND_OVERSIZE = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  opcode;
		logic [7:0]  data;
		logic [15:0] index;
		logic [15:0] length;
	} result_t;

	// CRC-8, MSB first, one whole byte per call
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/slfd_in_reg.sv
// ----------------------------------------------------------------------------
// slfd_in_reg: input register
// Captures one received byte per beat and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module slfd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       out_free,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic accept;
	logic advance;

	// stall while a held byte cannot move on
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// load payload on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

### rtl/slfd_parser.sv
// ----------------------------------------------------------------------------
// slfd_parser: frame parse state machine
// Walks sync, header, payload, CRC and trailer one byte per step and forms
// at most one result per byte.
// ----------------------------------------------------------------------------
module slfd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_s1,
	input  logic [15:0]      max_payload,
	output logic             res_valid,
	output slfd_pkg::result_t res
);

	slfd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  opcode_q, opcode_d;
	logic [15:0] length_q, length_d;
	logic [16:0] count_q, count_d;
	logic [7:0]  hcrc_q, hcrc_d;
	logic [7:0]  pcrc_q, pcrc_d;
	logic [7:0]  crc_in;
	logic [7:0]  crc_out;
	logic [15:0] len_full;
	logic [16:0] count_inc;
	logic        emit;
	slfd_pkg::kind_t kind;

	// one shared byte update: header bytes and payload bytes never overlap
	assign crc_in    = (phase_q == slfd_pkg::PH_OPCODE) ? 8'h00 :
		(phase_q == slfd_pkg::PH_PAYLOAD) ? pcrc_q : hcrc_q;
	assign crc_out   = slfd_pkg::crc8_update(crc_in, byte_s1);
	assign len_full  = {length_q[15:8], byte_s1};
	assign count_inc = count_q + 17'd1;

	// next state and result
	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		length_d = length_q;
		count_d  = count_q;
		hcrc_d   = hcrc_q;
		pcrc_d   = pcrc_q;
		emit     = 1'b0;
		kind     = slfd_pkg::KIND_DATA;
		unique case (phase_q)
			slfd_pkg::PH_SYNC2: begin
				phase_d = (byte_s1 == slfd_pkg::SYNC_SECOND) ? slfd_pkg::PH_OPCODE :
					slfd_pkg::PH_HUNT;
			end
			slfd_pkg::PH_OPCODE: begin
				opcode_d = byte_s1;
				hcrc_d   = crc_out;
				phase_d  = slfd_pkg::PH_LENHI;
			end
			slfd_pkg::PH_LENHI: begin
				length_d = {byte_s1, 8'h00};
				hcrc_d   = crc_out;
				phase_d  = slfd_pkg::PH_LENLO;
			end
			slfd_pkg::PH_LENLO: begin
				length_d = len_full;
				hcrc_d   = crc_out;
				count_d  = '0;
				pcrc_d   = 8'h00;
				if (len_full > max_payload) begin
					phase_d = slfd_pkg::PH_SKIP;
					emit    = 1'b1;
					kind    = slfd_pkg::KIND_OVERSIZE;
				end else if (len_full == 16'd0) begin
					phase_d = slfd_pkg::PH_CRC;
				end else begin
					phase_d = slfd_pkg::PH_PAYLOAD;
				end
			end
			slfd_pkg::PH_PAYLOAD: begin
				emit    = 1'b1;
				kind    = slfd_pkg::KIND_DATA;
				pcrc_d  = crc_out;
				count_d = count_inc;
				if (count_inc >= {1'b0, length_q}) begin
					phase_d = slfd_pkg::PH_CRC;
				end
			end
			slfd_pkg::PH_CRC: begin
				emit = 1'b1;
				if (byte_s1 == (hcrc_q ^ pcrc_q)) begin
					phase_d = slfd_pkg::PH_TRAILER;
					kind    = slfd_pkg::KIND_GOOD;
				end else begin
					phase_d = slfd_pkg::PH_HUNT;
					kind    = slfd_pkg::KIND_BAD;
				end
			end
			slfd_pkg::PH_TRAILER: begin
				phase_d = slfd_pkg::PH_HUNT;
			end
			slfd_pkg::PH_SKIP: begin
				count_d = count_inc;
				if (count_inc >= ({1'b0, length_q} + 17'd2)) begin
					phase_d = slfd_pkg::PH_HUNT;
				end
			end
			default: begin
				// hunting, and any code that is not a phase
				phase_d = (byte_s1 == slfd_pkg::SYNC_FIRST) ? slfd_pkg::PH_SYNC2 :
					slfd_pkg::PH_HUNT;
			end
		endcase
	end

	// result fields; data and index only for payload bytes
	always_comb begin
		res.kind   = kind;
		res.opcode = opcode_d;
		res.length = length_d;
		if (kind == slfd_pkg::KIND_DATA) begin
			res.data  = byte_s1;
			res.index = count_q[15:0];
		end else begin
			res.data  = 8'h00;
			res.index = 16'h0000;
		end
	end

	assign res_valid = step && emit;

	// advance parser state once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= slfd_pkg::PH_HUNT;
			opcode_q <= 8'h00;
			length_q <= 16'h0000;
			count_q  <= '0;
			hcrc_q   <= 8'h00;
			pcrc_q   <= 8'h00;
		end else if (step) begin
			phase_q  <= phase_d;
			opcode_q <= opcode_d;
			length_q <= length_d;
			count_q  <= count_d;
			hcrc_q   <= hcrc_d;
			pcrc_q   <= pcrc_d;
		end
	end

endmodule

### rtl/slfd_out_reg.sv
// ----------------------------------------------------------------------------
// slfd_out_reg: result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module slfd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  slfd_pkg::result_t res,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_stall,
	output slfd_pkg::result_t res_q
);

	logic out_valid_q;

	// room when empty or when the held beat leaves this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	// load new result, hold while stalled
	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			res_q <= res;
		end
	end

endmodule

### rtl/sync_length_frame_deframer_crc8_top.sv
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_crc8_top: sync-word frame deframer with CRC-8
// Input channel: one received byte per beat (in_valid / in_stall).
// Output channel: one event per beat (out_valid / out_stall): payload byte,
//   frame good, CRC mismatch, or oversize frame dropped.
// Config channel: cfg_valid / cfg_ready writes max_payload (reset 64);
//   cfg_ready is always high. Write only while the block is idle.
// Throughput: one byte per cycle while out_stall is low; the CRC-8 update
//   is a single unrolled step, so the parser state loop closes every cycle.
// Path: input register, then result register. Sync, opcode, length-high,
//   trailer and skipped bytes produce no event; a length-low byte yields
//   one only for an oversize frame.
// Reset: parser returns to sync hunting, both registers empty.
// Receiver stall: the result register holds; the input register fills and
//   then in_stall rises until the result beat is taken.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer_crc8_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [7:0]  frame_opcode,
	output logic [7:0]  payload_byte,
	output logic [15:0] byte_index,
	output logic [15:0] frame_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_free;
	logic              step;
	logic              res_valid;
	logic [15:0]       max_payload_q;
	slfd_pkg::result_t res;
	slfd_pkg::result_t res_q;

	// config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= slfd_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	assign step = valid_s1 && out_free;

	slfd_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.out_free (out_free),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	slfd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.byte_s1     (byte_s1),
		.max_payload (max_payload_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	slfd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	// unpack result beat
	assign event_kind   = res_q.kind;
	assign frame_opcode = res_q.opcode;
	assign payload_byte = res_q.data;
	assign byte_index   = res_q.index;
	assign frame_length = res_q.length;

endmodule
